@@ rtl/core/morse_symbol_playback_assert.svh @@
// assertion macros for the morse symbol playback block
`ifndef MORSE_SYMBOL_PLAYBACK_ASSERT_SVH
`define MORSE_SYMBOL_PLAYBACK_ASSERT_SVH

// clocked assertion, off while reset is applied
`define MSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define MSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/msp_pkg.sv @@
// types and constants shared by the morse symbol playback block
package msp_pkg;

  localparam int unsigned BufferDepthDefault = 512;
  localparam int unsigned TickW = 16;
  localparam int unsigned PaddrW = 5;
  localparam int unsigned PdataW = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [TickW-1:0] DotTicksRst = 16'd120;
  localparam logic [TickW-1:0] DashTicksRst = 16'd360;
  localparam logic [TickW-1:0] SymGapTicksRst = 16'd120;
  localparam logic [TickW-1:0] LetterGapTicksRst = 16'd360;
  localparam logic [TickW-1:0] WordGapTicksRst = 16'd800;

  localparam logic [RegIdxW-1:0] RegDot = 3'd0;
  localparam logic [RegIdxW-1:0] RegDash = 3'd1;
  localparam logic [RegIdxW-1:0] RegSymGap = 3'd2;
  localparam logic [RegIdxW-1:0] RegLetterGap = 3'd3;
  localparam logic [RegIdxW-1:0] RegWordGap = 3'd4;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_START  = 2'd2,
    KIND_STOP   = 2'd3
  } msp_kind_e;

  typedef enum logic [1:0] {
    SYM_DOT    = 2'd0,
    SYM_DASH   = 2'd1,
    SYM_LETTER = 2'd2,
    SYM_WORD   = 2'd3
  } msp_sym_e;

  typedef struct packed {
    msp_kind_e kind;
    msp_sym_e  symbol;
  } msp_in_t;

  typedef struct packed {
    logic led_on;
    logic playing_now;
    logic append_dropped;
  } msp_out_t;

endpackage

@@ rtl/core/msp_store.sv @@
// symbol store memory with registered read and same-address write forwarding
module msp_store #(
  parameter int unsigned Depth = msp_pkg::BufferDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  msp_pkg::msp_sym_e        wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output msp_pkg::msp_sym_e        rdata_o
);
  import msp_pkg::*;

  msp_sym_e mem_q [Depth];
  msp_sym_e rd_q;
  msp_sym_e fwd_data_q;
  logic     fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

@@ rtl/core/morse_symbol_playback.sv @@
// morse symbol playback: stored symbol list played on an led in a loop
// a result is registered and shown in the cycle after its input transfer
// throughput: one item per unstalled cycle; the next symbol is prefetched from
// the store, whose single read port follows the play position every cycle
// reset: playback stopped, store empty, led dark, tick registers at defaults
module morse_symbol_playback #(
  parameter int unsigned BufferDepth = msp_pkg::BufferDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  msp_pkg::msp_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output msp_pkg::msp_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msp_pkg::PaddrW-1:0]  paddr,
  input  logic [msp_pkg::PdataW-1:0]  pwdata,
  output logic [msp_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import msp_pkg::*;

  localparam int unsigned CntW = $clog2(BufferDepth + 1);
  localparam int unsigned AddrW = $clog2(BufferDepth);

  logic [TickW-1:0] dot_q, dash_q, sgap_q, lgap_q, wgap_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [TickW-1:0] rem_q, rem_d;
  logic             lit_q, lit_d;
  logic             playing_q, playing_d;
  logic             led_q, led_d;
  logic             dropped;
  logic             store_we;
  msp_sym_e         cur_sym;
  logic             in_xfer;
  logic             cfg_wr;
  logic [RegIdxW-1:0] reg_idx;
  logic             out_valid_q;
  msp_out_t         out_data_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer = in_valid_i && !in_stall_o;

  // configuration registers
  assign pready = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= DotTicksRst;
      dash_q <= DashTicksRst;
      sgap_q <= SymGapTicksRst;
      lgap_q <= LetterGapTicksRst;
      wgap_q <= WordGapTicksRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegDot:       dot_q <= pwdata[TickW-1:0];
        RegDash:      dash_q <= pwdata[TickW-1:0];
        RegSymGap:    sgap_q <= pwdata[TickW-1:0];
        RegLetterGap: lgap_q <= pwdata[TickW-1:0];
        RegWordGap:   wgap_q <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegDot:       prdata = {{(PdataW-TickW){1'b0}}, dot_q};
      RegDash:      prdata = {{(PdataW-TickW){1'b0}}, dash_q};
      RegSymGap:    prdata = {{(PdataW-TickW){1'b0}}, sgap_q};
      RegLetterGap: prdata = {{(PdataW-TickW){1'b0}}, lgap_q};
      RegWordGap:   prdata = {{(PdataW-TickW){1'b0}}, wgap_q};
      default:      prdata = '0;
    endcase
  end

  // playback control
  always_comb begin
    count_d = count_q;
    pos_d = pos_q;
    rem_d = rem_q;
    lit_d = lit_q;
    playing_d = playing_q;
    led_d = led_q;
    dropped = 1'b0;
    store_we = 1'b0;
    if (in_xfer) begin
      case (in_data_i.kind)
        KIND_TICK: begin
          if (playing_q) begin
            if (rem_q > TickW'(1)) begin
              rem_d = rem_q - TickW'(1);
            end else if (lit_q) begin
              lit_d = 1'b0;
              led_d = 1'b0;
              rem_d = sgap_q;
            end else if (pos_q >= count_q) begin
              pos_d = '0;
              led_d = 1'b0;
              rem_d = wgap_q;
            end else begin
              pos_d = pos_q + CntW'(1);
              case (cur_sym)
                SYM_DOT: begin
                  led_d = 1'b1;
                  lit_d = 1'b1;
                  rem_d = dot_q;
                end
                SYM_DASH: begin
                  led_d = 1'b1;
                  lit_d = 1'b1;
                  rem_d = dash_q;
                end
                SYM_LETTER: begin
                  led_d = 1'b0;
                  rem_d = lgap_q;
                end
                default: begin
                  led_d = 1'b0;
                  rem_d = wgap_q;
                end
              endcase
            end
          end
        end
        KIND_APPEND: begin
          if (playing_q || (count_q >= CntW'(BufferDepth))) begin
            dropped = 1'b1;
          end else begin
            store_we = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        KIND_START: begin
          if (count_q != '0) begin
            playing_d = 1'b1;
            pos_d = '0;
            lit_d = 1'b0;
            rem_d = '0;
            led_d = 1'b0;
          end
        end
        default: begin
          playing_d = 1'b0;
          pos_d = '0;
          lit_d = 1'b0;
          rem_d = '0;
          count_d = '0;
          led_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q <= '0;
      rem_q <= '0;
      lit_q <= 1'b0;
      playing_q <= 1'b0;
      led_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q <= pos_d;
      rem_q <= rem_d;
      lit_q <= lit_d;
      playing_q <= playing_d;
      led_q <= led_d;
    end
  end

  // store read follows the next play position
  msp_store #(
    .Depth(BufferDepth)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (store_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(in_data_i.symbol),
    .raddr_i(pos_d[AddrW-1:0]),
    .rdata_o(cur_sym)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q.led_on <= led_d;
      out_data_q.playing_now <= playing_d;
      out_data_q.append_dropped <= dropped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

@@ rtl/core/msp_checker.sv @@
// port-level assertions for the morse symbol playback block and their bind
`include "morse_symbol_playback_assert.svh"

module msp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input msp_pkg::msp_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input msp_pkg::msp_out_t out_data_o
);
  import msp_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  `MSP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `MSP_ASSERT(a_result_follows, in_xfer |=> out_valid_o, "no result after input transfer")
  `MSP_ASSERT(a_drop_only_append, in_xfer && (in_data_i.kind != KIND_APPEND) |=> !out_data_o.append_dropped, "drop flag on non-append")
  `MSP_ASSERT(a_stop_clears, in_xfer && (in_data_i.kind == KIND_STOP) |=> !out_data_o.playing_now && !out_data_o.led_on, "stop left playback running")
  `MSP_ASSERT(a_led_needs_play, out_valid_o && out_data_o.led_on |-> out_data_o.playing_now, "led lit while stopped")

endmodule

bind morse_symbol_playback msp_checker u_msp_checker (.*);
